>>> hdl/tac_pkg.sv
// Shared types, constants and register map of the temperature alarm controller.
package tac_pkg;

    localparam int TIME_BITS = 32;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    typedef logic [TIME_BITS-1:0] t_time;

    // item modes
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_INC    = 2'd1;
    localparam logic [1:0] MODE_DEC    = 2'd2;
    localparam logic [1:0] MODE_SAMPLE = 2'd3;

    // reported state codes
    localparam logic [1:0] SYS_INIT  = 2'd0;
    localparam logic [1:0] SYS_MON   = 2'd1;
    localparam logic [1:0] SYS_ADJ   = 2'd2;
    localparam logic [1:0] SYS_ALARM = 2'd3;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_DEBOUNCE = 3'd0;
    localparam logic [2:0] REG_TIMEOUT  = 3'd1;
    localparam logic [2:0] REG_STEP     = 3'd2;
    localparam logic [2:0] REG_SP_MAX   = 3'd3;
    localparam logic [2:0] REG_SP_MIN   = 3'd4;

    localparam logic [15:0]        RST_DEBOUNCE = 16'd200;
    localparam logic [15:0]        RST_TIMEOUT  = 16'd3000;
    localparam logic [10:0]        RST_STEP     = 11'd80;
    localparam logic signed [11:0] RST_SP_MAX   = 12'sd1600;
    localparam logic signed [11:0] RST_SP_MIN   = -12'sd800;
    localparam logic signed [11:0] RST_SETPOINT = 12'sd400;

    // bar graph thresholds on |setpoint - temperature|
    localparam logic [11:0] BAR_LVL4 = 12'd32;
    localparam logic [11:0] BAR_LVL3 = 12'd80;
    localparam logic [11:0] BAR_LVL2 = 12'd160;
    localparam logic [11:0] BAR_LVL1 = 12'd320;

    localparam logic [3:0] LED_ALL   = 4'hF;
    localparam logic [3:0] LED_THREE = 4'h7;
    localparam logic [3:0] LED_TWO   = 4'h3;
    localparam logic [3:0] LED_ONE   = 4'h1;
    localparam logic [3:0] LED_NONE  = 4'h0;

    typedef enum logic [3:0] {
        ST_INIT  = 4'b0001,
        ST_MON   = 4'b0010,
        ST_ADJ   = 4'b0100,
        ST_ALARM = 4'b1000
    } t_state;

    typedef struct packed {
        logic [15:0]        press_holdoff;
        logic [15:0]        adjust_timeout_ticks;
        logic [10:0]        setpoint_step;
        logic signed [11:0] setpoint_max;
        logic signed [11:0] setpoint_min;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [11:0] temperature;
    } t_item;

    typedef struct packed {
        logic [3:0]         led_bar;
        logic               buzzer_on;
        logic [1:0]         system_state;
        logic signed [11:0] alarm_setpoint;
        logic               display_update;
        logic               log_record;
    } t_result;

endpackage

>>> hdl/tac_if.sv
// Valid/ready channel interfaces for input items and result items.
interface tac_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [11:0] temperature;

    modport source (output valid, output mode, output temperature, input ready);
    modport sink   (input valid, input mode, input temperature, output ready);
endinterface

interface tac_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         led_bar;
    logic               buzzer_on;
    logic [1:0]         system_state;
    logic signed [11:0] alarm_setpoint;
    logic               display_update;
    logic               log_record;

    modport source (output valid, output led_bar, output buzzer_on, output system_state,
                    output alarm_setpoint, output display_update, output log_record,
                    input ready);
    modport sink   (input valid, input led_bar, input buzzer_on, input system_state,
                    input alarm_setpoint, input display_update, input log_record,
                    output ready);
endinterface

>>> hdl/temperature_alarm_controller.sv
// Temperature alarm controller top level: input register, result register, config port.
// An accepted item is held in the input register; its result is registered in the result
// register, from which it is offered, when the core fires, which waits on a full result register.
// One item per cycle is sustained; the only stall is a full result register not taken.
// Synchronous active-low reset empties both registers, loads register defaults,
// clears time counters and sets the setpoint to 25 degrees in the initialising state.
module temperature_alarm_controller (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tac_in_if.sink                     i_in,
    tac_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tac_pkg::ADDR_W-1:0] paddr,
    input  logic [tac_pkg::DATA_W-1:0] pwdata,
    output logic [tac_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import tac_pkg::*;

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result result;
    logic    advance;
    logic    fire;

    tac_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tac_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_item   (r_in),
        .i_fire   (fire),
        .o_result (result)
    );

    assign advance    = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.mode        <= i_in.mode;
            r_in.temperature <= i_in.temperature;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.led_bar        = r_out.led_bar;
    assign o_out.buzzer_on      = r_out.buzzer_on;
    assign o_out.system_state   = r_out.system_state;
    assign o_out.alarm_setpoint = r_out.alarm_setpoint;
    assign o_out.display_update = r_out.display_update;
    assign o_out.log_record     = r_out.log_record;

endmodule

>>> hdl/tac_cfg.sv
// APB configuration register file.
module tac_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tac_pkg::ADDR_W-1:0] paddr,
    input  logic [tac_pkg::DATA_W-1:0] pwdata,
    output logic [tac_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output tac_pkg::t_cfg              o_cfg
);
    import tac_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_holdoff        <= RST_DEBOUNCE;
            r_cfg.adjust_timeout_ticks <= RST_TIMEOUT;
            r_cfg.setpoint_step        <= RST_STEP;
            r_cfg.setpoint_max         <= RST_SP_MAX;
            r_cfg.setpoint_min         <= RST_SP_MIN;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DEBOUNCE: r_cfg.press_holdoff        <= pwdata[15:0];
                REG_TIMEOUT:  r_cfg.adjust_timeout_ticks <= pwdata[15:0];
                REG_STEP:     r_cfg.setpoint_step        <= pwdata[10:0];
                REG_SP_MAX:   r_cfg.setpoint_max         <= $signed(pwdata[11:0]);
                REG_SP_MIN:   r_cfg.setpoint_min         <= $signed(pwdata[11:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DEBOUNCE: prdata = DATA_W'(r_cfg.press_holdoff);
            REG_TIMEOUT:  prdata = DATA_W'(r_cfg.adjust_timeout_ticks);
            REG_STEP:     prdata = DATA_W'(r_cfg.setpoint_step);
            REG_SP_MAX:   prdata = DATA_W'($unsigned(r_cfg.setpoint_max));
            REG_SP_MIN:   prdata = DATA_W'($unsigned(r_cfg.setpoint_min));
            default:      prdata = '0;
        endcase
    end

endmodule

>>> hdl/tac_core.sv
// Controller state: time, debounce, setpoint and the sample state machine.
module tac_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tac_pkg::t_cfg    i_cfg,
    input  tac_pkg::t_item   i_item,
    input  logic             i_fire,
    output tac_pkg::t_result o_result
);
    import tac_pkg::*;

    t_time              r_tick, n_tick;
    t_time              r_last_inc, n_last_inc;
    t_time              r_last_dec, n_last_dec;
    t_time              r_adj_start, n_adj_start;
    logic signed [11:0] r_setpoint, n_setpoint;
    t_state             r_state, n_state;
    logic               r_blink, n_blink;
    logic [3:0]         r_led, n_led;
    logic               r_buzzer, n_buzzer;

    logic               disp, logr;
    logic               inc_ok, dec_ok, press_ok;
    logic signed [12:0] sp13, t13, step13, inc_sum, dec_diff, sp_gap;
    logic [11:0]        dist_abs;
    logic [3:0]         bar;
    logic               temp_ge;
    logic               timed_out;
    logic [11:0]        inc_val, dec_val;

    assign inc_ok = (r_tick - r_last_inc) > TIME_BITS'(i_cfg.press_holdoff);
    assign dec_ok = (r_tick - r_last_dec) > TIME_BITS'(i_cfg.press_holdoff);
    assign timed_out = (r_tick - r_adj_start) >= TIME_BITS'(i_cfg.adjust_timeout_ticks);

    assign sp13     = {r_setpoint[11], r_setpoint};
    assign t13      = {i_item.temperature[11], i_item.temperature};
    assign step13   = $signed({2'b00, i_cfg.setpoint_step});
    assign inc_sum  = sp13 + step13;
    assign dec_diff = sp13 - step13;
    assign inc_val  = (inc_sum > $signed({i_cfg.setpoint_max[11], i_cfg.setpoint_max})) ?
                      i_cfg.setpoint_max : inc_sum[11:0];
    assign dec_val  = (dec_diff < $signed({i_cfg.setpoint_min[11], i_cfg.setpoint_min})) ?
                      i_cfg.setpoint_min : dec_diff[11:0];
    assign temp_ge  = i_item.temperature >= r_setpoint;
    assign sp_gap   = sp13 - t13;
    assign dist_abs = sp_gap[12] ? 12'(-sp_gap) : sp_gap[11:0];

    always_comb begin
        priority if (dist_abs <= BAR_LVL4) begin
            bar = LED_ALL;
        end else if (dist_abs <= BAR_LVL3) begin
            bar = LED_THREE;
        end else if (dist_abs <= BAR_LVL2) begin
            bar = LED_TWO;
        end else if (dist_abs <= BAR_LVL1) begin
            bar = LED_ONE;
        end else begin
            bar = LED_NONE;
        end
    end

    always_comb begin
        n_tick      = r_tick;
        n_last_inc  = r_last_inc;
        n_last_dec  = r_last_dec;
        n_adj_start = r_adj_start;
        n_setpoint  = r_setpoint;
        n_state     = r_state;
        n_blink     = r_blink;
        n_led       = r_led;
        n_buzzer    = r_buzzer;
        disp        = 1'b0;
        logr        = 1'b0;
        press_ok    = 1'b0;
        unique case (i_item.mode)
            MODE_TICK: begin
                n_tick = r_tick + 1'b1;
            end
            MODE_INC: begin
                if (inc_ok) begin
                    press_ok    = 1'b1;
                    n_last_inc  = r_tick;
                    n_adj_start = r_tick;
                    n_state     = ST_ADJ;
                    n_setpoint  = inc_val;
                end
            end
            MODE_DEC: begin
                if (dec_ok) begin
                    press_ok    = 1'b1;
                    n_last_dec  = r_tick;
                    n_adj_start = r_tick;
                    n_state     = ST_ADJ;
                    n_setpoint  = dec_val;
                end
            end
            MODE_SAMPLE: begin
                unique case (r_state)
                    ST_INIT: begin
                        n_state = ST_MON;
                    end
                    ST_MON: begin
                        n_led    = bar;
                        n_buzzer = 1'b0;
                        disp     = 1'b1;
                        logr     = 1'b1;
                        if (temp_ge) begin
                            n_state = ST_ALARM;
                        end
                    end
                    ST_ADJ: begin
                        n_led    = LED_NONE;
                        n_buzzer = 1'b0;
                        disp     = 1'b1;
                        if (timed_out) begin
                            n_state = temp_ge ? ST_ALARM : ST_MON;
                        end
                    end
                    default: begin
                        n_blink  = ~r_blink;
                        n_led    = {4{~r_blink}};
                        n_buzzer = 1'b1;
                        disp     = 1'b1;
                        logr     = 1'b1;
                        if (!temp_ge) begin
                            n_state = ST_MON;
                        end
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_last_inc  <= '0;
            r_last_dec  <= '0;
            r_adj_start <= '0;
            r_setpoint  <= RST_SETPOINT;
            r_state     <= ST_INIT;
            r_blink     <= 1'b0;
            r_led       <= LED_NONE;
            r_buzzer    <= 1'b0;
        end else if (i_fire) begin
            r_tick      <= n_tick;
            r_last_inc  <= n_last_inc;
            r_last_dec  <= n_last_dec;
            r_adj_start <= n_adj_start;
            r_setpoint  <= n_setpoint;
            r_state     <= n_state;
            r_blink     <= n_blink;
            r_led       <= n_led;
            r_buzzer    <= n_buzzer;
        end
    end

    always_comb begin
        o_result.led_bar        = n_led;
        o_result.buzzer_on      = n_buzzer;
        o_result.alarm_setpoint = n_setpoint;
        o_result.display_update = disp;
        o_result.log_record     = logr;
        unique case (n_state)
            ST_MON:   o_result.system_state = SYS_MON;
            ST_ADJ:   o_result.system_state = SYS_ADJ;
            ST_ALARM: o_result.system_state = SYS_ALARM;
            default:  o_result.system_state = SYS_INIT;
        endcase
    end

    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.mode == MODE_TICK |=> r_tick == $past(r_tick) + 1'b1)
        else $error("tick did not advance time");

    a_press_adjust: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && press_ok |=> r_state == ST_ADJ && r_adj_start == $past(r_tick))
        else $error("accepted press did not enter adjusting");

    a_no_disp_off_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.mode != MODE_SAMPLE |-> !o_result.display_update
                                                 && !o_result.log_record)
        else $error("display or log flagged on a non-sample item");

    a_alarm_buzzer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.mode == MODE_SAMPLE && r_state == ST_ALARM
        |=> r_buzzer && r_blink != $past(r_blink))
        else $error("alarm sample did not drive buzzer and blink");

endmodule

>>> tb/sv/tac_checker.sv
// Checker for the temperature alarm controller: follows config writes and both channels.
module tac_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tac_in_if                          i_in,
    tac_out_if                         i_out,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic                       i_pready,
    input  logic [tac_pkg::ADDR_W-1:0] i_paddr,
    input  logic [tac_pkg::DATA_W-1:0] i_pwdata,
    output int                         o_errors,
    output int                         o_pending
);
    import tac_pkg::*;

    logic [15:0]        cfg_debounce;
    logic [15:0]        cfg_timeout;
    logic [10:0]        cfg_step;
    logic signed [11:0] cfg_sp_max;
    logic signed [11:0] cfg_sp_min;

    t_time       now_ticks;
    t_time       inc_stamp;
    t_time       dec_stamp;
    t_time       adj_stamp;
    int          setpoint;
    logic [1:0]  ctrl_state;
    logic        blink;
    logic [3:0]  leds;
    logic        buzz;

    t_result     awaited_outputs[$];
    int          errors = 0;

    assign o_errors = errors;

    task automatic report(input string msg);
        errors++;
        $display("tac_checker: mismatch %0d: %s", errors, msg);
    endtask

    function automatic logic [3:0] bar_graph(input int sp, input int tv);
        int d;
        d = sp - tv;
        if (d < 0) d = -d;
        if (d <= int'(BAR_LVL4)) return LED_ALL;
        if (d <= int'(BAR_LVL3)) return LED_THREE;
        if (d <= int'(BAR_LVL2)) return LED_TWO;
        if (d <= int'(BAR_LVL1)) return LED_ONE;
        return LED_NONE;
    endfunction

    task automatic take_press(input logic up);
        t_time gap;
        int    step_v;
        int    lim;
        gap = up ? now_ticks - inc_stamp : now_ticks - dec_stamp;
        if (gap <= t_time'(cfg_debounce)) return;
        if (up) inc_stamp = now_ticks;
        else dec_stamp = now_ticks;
        ctrl_state = SYS_ADJ;
        adj_stamp  = now_ticks;
        step_v = cfg_step;
        if (up) begin
            lim = cfg_sp_max;
            setpoint = setpoint + step_v;
            if (setpoint > lim) setpoint = lim;
        end else begin
            lim = cfg_sp_min;
            setpoint = setpoint - step_v;
            if (setpoint < lim) setpoint = lim;
        end
    endtask

    task automatic apply_item(input logic [1:0] mode, input logic signed [11:0] temp,
                              output t_result r);
        int    tv;
        t_time gap;
        logic  disp;
        logic  logr;
        tv   = temp;
        disp = 1'b0;
        logr = 1'b0;
        case (mode)
            MODE_TICK: now_ticks = now_ticks + 1'b1;
            MODE_INC:  take_press(1'b1);
            MODE_DEC:  take_press(1'b0);
            default: begin
                case (ctrl_state)
                    SYS_INIT: ctrl_state = SYS_MON;
                    SYS_MON: begin
                        leds = bar_graph(setpoint, tv);
                        buzz = 1'b0;
                        disp = 1'b1;
                        logr = 1'b1;
                        if (tv >= setpoint) ctrl_state = SYS_ALARM;
                    end
                    SYS_ADJ: begin
                        disp = 1'b1;
                        leds = LED_NONE;
                        buzz = 1'b0;
                        gap  = now_ticks - adj_stamp;
                        if (gap >= t_time'(cfg_timeout))
                            ctrl_state = (tv >= setpoint) ? SYS_ALARM : SYS_MON;
                    end
                    default: begin
                        blink = ~blink;
                        leds  = blink ? LED_ALL : LED_NONE;
                        buzz  = 1'b1;
                        disp  = 1'b1;
                        logr  = 1'b1;
                        if (tv < setpoint) ctrl_state = SYS_MON;
                    end
                endcase
            end
        endcase
        r.led_bar        = leds;
        r.buzzer_on      = buzz;
        r.system_state   = ctrl_state;
        r.alarm_setpoint = 12'(setpoint);
        r.display_update = disp;
        r.log_record     = logr;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            cfg_debounce = RST_DEBOUNCE;
            cfg_timeout  = RST_TIMEOUT;
            cfg_step     = RST_STEP;
            cfg_sp_max   = RST_SP_MAX;
            cfg_sp_min   = RST_SP_MIN;
            now_ticks    = '0;
            inc_stamp    = '0;
            dec_stamp    = '0;
            adj_stamp    = '0;
            setpoint     = RST_SETPOINT;
            ctrl_state   = SYS_INIT;
            blink        = 1'b0;
            leds         = LED_NONE;
            buzz         = 1'b0;
            awaited_outputs.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_DEBOUNCE: cfg_debounce = i_pwdata[15:0];
                    REG_TIMEOUT:  cfg_timeout  = i_pwdata[15:0];
                    REG_STEP:     cfg_step     = i_pwdata[10:0];
                    REG_SP_MAX:   cfg_sp_max   = i_pwdata[11:0];
                    REG_SP_MIN:   cfg_sp_min   = i_pwdata[11:0];
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                got.led_bar        = i_out.led_bar;
                got.buzzer_on      = i_out.buzzer_on;
                got.system_state   = i_out.system_state;
                got.alarm_setpoint = i_out.alarm_setpoint;
                got.display_update = i_out.display_update;
                got.log_record     = i_out.log_record;
                if (awaited_outputs.size() == 0) begin
                    report("result transfer with nothing outstanding");
                end else begin
                    want = awaited_outputs.pop_front();
                    if (got.led_bar !== want.led_bar)
                        report($sformatf("led_bar %0h, expected %0h",
                                         got.led_bar, want.led_bar));
                    if (got.buzzer_on !== want.buzzer_on)
                        report($sformatf("buzzer_on %0b, expected %0b",
                                         got.buzzer_on, want.buzzer_on));
                    if (got.system_state !== want.system_state)
                        report($sformatf("system_state %0d, expected %0d",
                                         got.system_state, want.system_state));
                    if (got.alarm_setpoint !== want.alarm_setpoint)
                        report($sformatf("alarm_setpoint %0d, expected %0d",
                                         got.alarm_setpoint, want.alarm_setpoint));
                    if (got.display_update !== want.display_update)
                        report($sformatf("display_update %0b, expected %0b",
                                         got.display_update, want.display_update));
                    if (got.log_record !== want.log_record)
                        report($sformatf("log_record %0b, expected %0b",
                                         got.log_record, want.log_record));
                end
            end
            if (i_in.valid && i_in.ready) begin
                apply_item(i_in.mode, i_in.temperature, want);
                awaited_outputs.push_back(want);
            end
        end
        o_pending <= awaited_outputs.size();
    end

endmodule

>>> tb/sv/tb.sv
// Testbench top: clock, reset, config writes, item stimulus and the final verdict.
module tb;
    import tac_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd5;
    localparam int         DRAIN_CYCLES = 4;
    localparam int         PHASE_ITEMS  = 190;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                calm;
    int                  errors;
    int                  pending;

    tac_in_if  in_ch ();
    tac_out_if out_ch ();

    temperature_alarm_controller uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tac_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_pready  (pready),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        out_ch.ready <= calm || ($urandom_range(99) >= 38);
    end

    initial begin
        #2000000;
        $display("tb: errors");
        $finish;
    end

    task automatic send_item(input logic [1:0] m, input logic signed [11:0] t);
        while (!calm && $urandom_range(99) < 38) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= m;
        in_ch.temperature <= t;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // caller has already lowered valid; the first edge lets the transfer count settle
    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [1:0] pick_mode();
        int r;
        r = $urandom_range(99);
        if (r < 50) return MODE_TICK;
        if (r < 62) return MODE_INC;
        if (r < 74) return MODE_DEC;
        return MODE_SAMPLE;
    endfunction

    function automatic logic signed [11:0] pick_temp();
        int off;
        if ($urandom_range(99) < 20) return 12'($urandom);
        off = $urandom_range(2600);
        return 12'(off - 900);
    endfunction

    task automatic run_phase(input logic [15:0] deb, input logic [15:0] tmo,
                             input logic [10:0] step, input logic signed [11:0] sp_max,
                             input logic signed [11:0] sp_min, input logic quiet,
                             input logic noisy);
        calm <= quiet;
        apb_write(REG_DEBOUNCE, noisy ? {16'($urandom), deb}    : DATA_W'(deb));
        apb_write(REG_TIMEOUT,  noisy ? {16'($urandom), tmo}    : DATA_W'(tmo));
        apb_write(REG_STEP,     noisy ? {21'($urandom), step}   : DATA_W'(step));
        apb_write(REG_SP_MAX,   noisy ? {20'($urandom), sp_max} : {20'd0, sp_max});
        apb_write(REG_SP_MIN,   noisy ? {20'($urandom), sp_min} : {20'd0, sp_min});
        if (noisy) apb_write(REG_UNUSED, $urandom);
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k == PHASE_ITEMS / 2) begin
                in_ch.valid <= 1'b0;
                drain();
            end
            send_item(pick_mode(), pick_temp());
        end
        in_ch.valid <= 1'b0;
        drain();
    endtask

    initial begin
        in_ch.valid       <= 1'b0;
        in_ch.mode        <= MODE_TICK;
        in_ch.temperature <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        calm              <= 1'b0;
        i_rst_n           <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: early presses are debounced away, then the state walk
        send_item(MODE_INC,    12'sd0);
        send_item(MODE_DEC,    12'sd0);
        send_item(MODE_SAMPLE, 12'sd400);
        send_item(MODE_SAMPLE, -12'sd2048);
        send_item(MODE_SAMPLE, 12'sd2047);
        send_item(MODE_SAMPLE, 12'sd2047);
        send_item(MODE_SAMPLE, 12'sd1600);
        send_item(MODE_SAMPLE, -12'sd800);
        send_item(MODE_SAMPLE, 12'sd368);
        send_item(MODE_SAMPLE, 12'sd367);
        send_item(MODE_SAMPLE, 12'sd320);
        send_item(MODE_SAMPLE, 12'sd319);
        send_item(MODE_SAMPLE, 12'sd240);
        send_item(MODE_SAMPLE, 12'sd239);
        send_item(MODE_SAMPLE, 12'sd80);
        send_item(MODE_SAMPLE, 12'sd79);
        send_item(MODE_SAMPLE, 12'sd400);
        send_item(MODE_SAMPLE, 12'sd401);
        send_item(MODE_SAMPLE, 12'sd399);
        send_item(MODE_TICK,   -12'sd1);
        send_item(MODE_TICK,   12'sd2047);
        send_item(MODE_INC,    12'sd0);
        send_item(MODE_SAMPLE, 12'sd0);
        in_ch.valid <= 1'b0;
        drain();

        run_phase(16'd0,     16'd0,     11'd80,   12'sd1600,  -12'sd800,  1'b0, 1'b0);
        run_phase(16'd3,     16'd12,    11'd1,    12'sd1600,  -12'sd800,  1'b0, 1'b1);
        run_phase(16'd5,     16'd25,    11'd1600, 12'sd1600,  -12'sd800,  1'b0, 1'b0);
        run_phase(16'd2,     16'd8,     11'd2047, 12'sd2047,  -12'sd2048, 1'b1, 1'b1);
        run_phase(16'd1,     16'd5,     11'd0,    12'sd400,   12'sd400,   1'b0, 1'b0);
        run_phase(16'd4,     16'd20,    11'd300,  -12'sd800,  12'sd1600,  1'b0, 1'b1);
        run_phase(16'd65535, 16'd65535, 11'd40,   12'sd100,   -12'sd100,  1'b0, 1'b0);
        run_phase(16'd0,     16'd65535, 11'd120,  12'sd1000,  -12'sd300,  1'b0, 1'b1);

        if (errors == 0 && pending == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
